[design/sti_pkg.sv]
// ----------------------------------------------------------------------------
// sti_pkg
// Shared types and constants for the sorted timestamp insert table.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int CAPACITY = 64;
  localparam int TAG_BITS = 16;

  localparam int KEY_W  = 20;
  localparam int WORD_W = KEY_W + TAG_BITS;
  localparam int ADDR_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = 6;
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [2:0] {
    STAT_INSERTED = 3'd0,
    STAT_INVALID  = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_READ_OK  = 3'd3,
    STAT_BEYOND   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_RD_ISSUE,
    ST_SH_RD,
    ST_SH_CMP,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic rd_en;
    logic rd_item;   // read address from item index, else from j-1
    logic wr_en;
    logic wr_new;    // write the new entry, else the entry just read
    logic j_dec;
    logic cnt_inc;
    logic load_out;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    status_t st;
    logic    j_zero;
    logic    ge;
    logic    out_busy;
  } dp_stat_t;

endpackage

[design/sti_ctrl.sv]
// ----------------------------------------------------------------------------
// sti_ctrl
// Sequencer for the table: dispatch, read, shift-down insert, result hand-off.
// ----------------------------------------------------------------------------
module sti_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sti_pkg::dp_stat_t stat,
  output sti_pkg::ctl_cmd_t cmd
);

  sti_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sti_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      sti_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sti_pkg::ST_DISP;
        end
      end
      sti_pkg::ST_DISP: begin
        if (stat.st == sti_pkg::STAT_READ_OK) begin
          state_nxt = sti_pkg::ST_RD_ISSUE;
        end else if (stat.st == sti_pkg::STAT_INSERTED) begin
          state_nxt = sti_pkg::ST_SH_RD;
        end else begin
          state_nxt = sti_pkg::ST_DONE;
        end
      end
      sti_pkg::ST_RD_ISSUE: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_item = 1'b1;
        state_nxt   = sti_pkg::ST_DONE;
      end
      sti_pkg::ST_SH_RD: begin
        if (stat.j_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = sti_pkg::ST_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = sti_pkg::ST_SH_CMP;
        end
      end
      sti_pkg::ST_SH_CMP: begin
        cmd.wr_en = 1'b1;
        // stored key >= new key moves down, so the new entry lands ahead of equals
        if (stat.ge) begin
          cmd.j_dec = 1'b1;
          state_nxt = sti_pkg::ST_SH_RD;
        end else begin
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = sti_pkg::ST_DONE;
        end
      end
      sti_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = sti_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sti_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[design/sti_dp.sv]
// ----------------------------------------------------------------------------
// sti_dp
// Datapath: item registers, entry memory, count, shift pointer, result register.
// ----------------------------------------------------------------------------
module sti_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  sti_pkg::ctl_cmd_t cmd,
  output sti_pkg::dp_stat_t stat,
  input  logic              in_mode,
  input  logic [3:0]        in_month,
  input  logic [4:0]        in_day,
  input  logic [4:0]        in_hour,
  input  logic [5:0]        in_minute,
  input  logic [15:0]       in_tag,
  input  logic [5:0]        in_read_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [5:0]        out_position,
  output logic [6:0]        out_entry_count,
  output logic [3:0]        out_month,
  output logic [4:0]        out_day,
  output logic [4:0]        out_hour,
  output logic [5:0]        out_minute,
  output logic [15:0]       out_tag
);

  localparam int KW = sti_pkg::KEY_W;
  localparam int TW = sti_pkg::TAG_BITS;
  localparam int WW = sti_pkg::WORD_W;
  localparam int AW = sti_pkg::ADDR_W;
  localparam int NW = sti_pkg::CNT_W;
  localparam int CW = sti_pkg::CMP_W;

  logic [WW-1:0] mem [sti_pkg::CAPACITY];
  logic [WW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [WW-1:0] wr_data;

  logic [KW-1:0]   key_r;
  logic [TW-1:0]   tag_r;
  logic [5:0]      ridx_r;
  logic [5:0]      pos_r;
  sti_pkg::status_t st_r, st_nxt;
  logic [AW-1:0]   j_r;
  logic [NW-1:0]   count_r;
  logic            out_valid_r;

  logic [2:0]  out_status_r;
  logic [5:0]  out_position_r;
  logic [6:0]  out_entry_count_r;
  logic [KW-1:0] out_key_r;
  logic [15:0] out_tag_r;

  logic date_ok, full, hit;

  assign date_ok = (in_month >= 4'd1) && (in_month <= 4'd12) && (in_day != 5'd0) &&
                   (in_hour <= 5'd23) && (in_minute <= 6'd59);
  assign full    = (count_r >= NW'(sti_pkg::CAPACITY));
  assign hit     = (CW'(in_read_index) < CW'(count_r));

  always_comb begin
    if (in_mode) begin
      st_nxt = hit ? sti_pkg::STAT_READ_OK : sti_pkg::STAT_BEYOND;
    end else if (full) begin
      st_nxt = sti_pkg::STAT_FULL;
    end else if (!date_ok) begin
      st_nxt = sti_pkg::STAT_INVALID;
    end else begin
      st_nxt = sti_pkg::STAT_INSERTED;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r  <= {in_month, in_day, in_hour, in_minute};
      tag_r  <= TW'(in_tag);
      ridx_r <= in_read_index;
      st_r   <= st_nxt;
      pos_r  <= in_mode ? in_read_index : 6'd0;
      j_r    <= AW'(count_r);
    end else begin
      if (cmd.j_dec) begin
        j_r <= j_r - 1'b1;
      end
      if (cmd.wr_en && cmd.wr_new) begin
        pos_r <= 6'(j_r);
      end
    end
  end

  // entry memory: one write port, one registered read port
  assign rd_addr = cmd.rd_item ? AW'(ridx_r) : AW'(j_r - 1'b1);
  assign wr_data = cmd.wr_new ? {key_r, tag_r} : rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[j_r] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + 1'b1;
      end
      out_valid_r <= cmd.load_out | (out_valid_r & ~out_ready);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r      <= st_r;
      out_position_r    <= pos_r;
      out_entry_count_r <= 7'(count_r);
      if (st_r == sti_pkg::STAT_READ_OK) begin
        out_key_r <= rd_data_r[WW-1 -: KW];
        out_tag_r <= 16'(rd_data_r[TW-1:0]);
      end else begin
        out_key_r <= '0;
        out_tag_r <= '0;
      end
    end
  end

  assign stat.st       = st_r;
  assign stat.j_zero   = (j_r == '0);
  assign stat.ge       = (rd_data_r[WW-1 -: KW] >= key_r);
  assign stat.out_busy = out_valid_r & ~out_ready;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_position_r;
  assign out_entry_count = out_entry_count_r;
  assign out_month       = out_key_r[19:16];
  assign out_day         = out_key_r[15:11];
  assign out_hour        = out_key_r[10:6];
  assign out_minute      = out_key_r[5:0];
  assign out_tag         = out_tag_r;

endmodule

[design/sorted_timestamp_insert_table.sv]
// ----------------------------------------------------------------------------
// sorted_timestamp_insert_table
// Table of entries kept in ascending month/day/hour/minute order, with insert
// and read-by-index items.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | mode, month, day, hour, minute, tag, index
//  out     | out_valid / out_ready| status, position, count, date/time, tag
//
// One item at a time. Rejected inserts and reads beyond the count go from
// dispatch straight to the result; a read first reads the entry. An insert
// moves down every entry whose key is not below the new one, then writes the
// new entry: each move reads the entry above, compares it and writes it one
// place down. No clearing pass; reset zeroes the count and result valid only.
// A stalled result waits in the output register; in_ready returns once the
// next result has been loaded behind it.
module sorted_timestamp_insert_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [15:0] in_tag,
  input  logic [5:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_position,
  output logic [6:0]  out_entry_count,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [15:0] out_tag
);

  sti_pkg::ctl_cmd_t cmd;
  sti_pkg::dp_stat_t stat;

  sti_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sti_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_mode),
    .in_month        (in_month),
    .in_day          (in_day),
    .in_hour         (in_hour),
    .in_minute       (in_minute),
    .in_tag          (in_tag),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_count (out_entry_count),
    .out_month       (out_month),
    .out_day         (out_day),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_tag         (out_tag)
  );

endmodule

[design/sti_chk.sv]
// ----------------------------------------------------------------------------
// sti_chk
// Port-level checks for the sorted timestamp insert table.
// ----------------------------------------------------------------------------
module sti_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [5:0]  out_position,
  input logic [6:0]  out_entry_count,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day,
  input logic [4:0]  out_hour,
  input logic [5:0]  out_minute,
  input logic [15:0] out_tag
);

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_position) && $stable(out_entry_count) && $stable(out_tag))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 3'(sti_pkg::STAT_BEYOND))
    else $error("status code out of range");

  // only a successful read carries entry fields
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != 3'(sti_pkg::STAT_READ_OK)) |->
      out_month == 4'd0 && out_day == 5'd0 && out_hour == 5'd0 &&
      out_minute == 6'd0 && out_tag == 16'd0)
    else $error("entry fields set on a non-read result");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 3'(sti_pkg::STAT_FULL)) |->
      out_entry_count == 7'(sti_pkg::CAPACITY) && out_position == 6'd0)
    else $error("full reported with table not full");

  a_read_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 3'(sti_pkg::STAT_READ_OK)) |->
      out_month >= 4'd1 && out_month <= 4'd12 && out_day != 5'd0 &&
      out_hour <= 5'd23 && out_minute <= 6'd59)
    else $error("read returned an invalid date or time");

endmodule

bind sorted_timestamp_insert_table sti_chk u_sti_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_position    (out_position),
  .out_entry_count (out_entry_count),
  .out_month       (out_month),
  .out_day         (out_day),
  .out_hour        (out_hour),
  .out_minute      (out_minute),
  .out_tag         (out_tag)
);
